[rtl/ntc_pkg.sv]
// ----------------------------------------------------------------------------
// NTC thermistor to temperature: shared constants
// Conversion constants and the resistance/temperature curve.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int unsigned AdcBitsDef   = 10;
  localparam int unsigned TableEntries = 14;
  localparam int unsigned SegCount     = TableEntries - 1;
  localparam int unsigned SegW         = $clog2(SegCount);

  localparam int unsigned VrefMv     = 3300;
  localparam int unsigned PullupOhms = 100000;
  localparam int unsigned OorTemp    = 50;

  // mv stays below VrefMv
  localparam int unsigned MvW  = 12;
  localparam int unsigned PuW  = 17;
  localparam int unsigned NumW = MvW + PuW;
  localparam int unsigned ResW = 18;
  localparam int unsigned DegW = 7;
  localparam int unsigned DtW  = 4;
  localparam int unsigned ProdW = ResW + DtW;

  typedef logic [ResW-1:0] ohms_t;
  typedef logic [DegW-1:0] deg_t;

  localparam ohms_t CurveOhms [TableEntries] = '{
    18'd166500, 18'd128475, 18'd99500, 18'd75530, 18'd46050, 18'd31070,
    18'd20800,  18'd14490,  18'd10000, 18'd7160,  18'd5220,  18'd3860,
    18'd3316,   18'd2873
  };

  localparam deg_t CurveDeg [TableEntries] = '{
    7'd15, 7'd20, 7'd25, 7'd30, 7'd40, 7'd50, 7'd60,
    7'd70, 7'd80, 7'd90, 7'd100, 7'd110, 7'd120, 7'd125
  };

endpackage

[rtl/ntc_adc_to_temperature_core.sv]
// ----------------------------------------------------------------------------
// NTC thermistor ADC word to temperature
// Each taken word is registered through every stage below before its result strobe.
// Throughput: one word per cycle; set by the two bit-per-stage dividers.
// busy is never raised; the receiver cannot stall the pipeline.
// Reset clears all stage valid bits; no word in flight survives reset.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature_core
  import ntc_pkg::*;
#(
  parameter int unsigned ADC_BITS = AdcBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ADC_BITS-1:0] adc_sample_i,
  output logic                valid_o,
  output logic [DegW-1:0]     temperature_c_o,
  output logic                out_of_range_o
);

  localparam int unsigned MulW = ADC_BITS + MvW;
  localparam int unsigned Lat  = NumW + DtW + 6;

  assign busy = 1'b0;

  // stage 1: millivolts
  logic           v1_q;
  logic [MvW-1:0] mv_q;
  logic [MulW-1:0] mv_mul;
  assign mv_mul = MulW'(adc_sample_i) * MulW'(VrefMv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start & ~busy;
  end
  always_ff @(posedge clk_i) begin
    mv_q <= MvW'(mv_mul >> ADC_BITS);
  end

  // stage 2: dividend and divisor
  logic            v2_q;
  logic [NumW-1:0] num_q;
  logic [MvW-1:0]  den_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    num_q <= NumW'(mv_q) * NumW'(PullupOhms);
    den_q <= MvW'(VrefMv) - mv_q;
  end

  // resistance divider, one quotient bit per stage
  logic            dv_q  [NumW];
  logic [NumW-1:0] dn_q  [NumW];
  logic [MvW-1:0]  dr_q  [NumW];
  logic [MvW-1:0]  dd_q  [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_div1
    logic            v_in;
    logic [NumW-1:0] n_in;
    logic [MvW-1:0]  r_in;
    logic [MvW-1:0]  d_in;
    logic [MvW:0]    trial;
    logic            ge;
    if (k == 0) begin : g_first
      assign v_in = v2_q;
      assign n_in = num_q;
      assign r_in = '0;
      assign d_in = den_q;
    end else begin : g_next
      assign v_in = dv_q[k-1];
      assign n_in = dn_q[k-1];
      assign r_in = dr_q[k-1];
      assign d_in = dd_q[k-1];
    end
    assign trial = {r_in, n_in[NumW-1]};
    assign ge    = trial >= {1'b0, d_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k] <= 1'b0;
      else         dv_q[k] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      dn_q[k] <= {n_in[NumW-2:0], ge};
      dr_q[k] <= ge ? MvW'(trial - {1'b0, d_in}) : trial[MvW-1:0];
      dd_q[k] <= d_in;
    end
  end

  logic [NumW-1:0] res;
  assign res = dn_q[NumW-1];

  // segment search
  logic            vs_q;
  logic            oor_s_q;
  logic [SegW-1:0] seg_q;
  logic [ResW-1:0] res_s_q;
  logic            hit_any;
  logic [SegW-1:0] hit_idx;

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = SegCount - 1; i >= 0; i--) begin
      if ((NumW'(CurveOhms[i]) > res) && (NumW'(CurveOhms[i+1]) <= res)) begin
        hit_any = 1'b1;
        hit_idx = SegW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vs_q <= 1'b0;
    else         vs_q <= dv_q[NumW-1];
  end
  always_ff @(posedge clk_i) begin
    oor_s_q <= ~hit_any;
    seg_q   <= hit_idx;
    res_s_q <= res[ResW-1:0];
  end

  // segment fetch
  logic            vf_q;
  logic            oor_f_q;
  logic [ResW-1:0] off_q;
  logic [ResW-1:0] span_q;
  logic [DtW-1:0]  dt_q;
  logic [DegW-1:0] t0_f_q;
  logic [DegW-1:0] t1;

  assign t1 = CurveDeg[SegW'(seg_q + 1'b1)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else         vf_q <= vs_q;
  end
  always_ff @(posedge clk_i) begin
    oor_f_q <= oor_s_q;
    off_q   <= CurveOhms[seg_q] - res_s_q;
    span_q  <= CurveOhms[seg_q] - CurveOhms[SegW'(seg_q + 1'b1)];
    dt_q    <= DtW'(t1 - CurveDeg[seg_q]);
    t0_f_q  <= CurveDeg[seg_q];
  end

  // product
  logic             vm_q;
  logic             oor_m_q;
  logic [ProdW-1:0] prod_q;
  logic [ResW-1:0]  span_m_q;
  logic [DegW-1:0]  t0_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else         vm_q <= vf_q;
  end
  always_ff @(posedge clk_i) begin
    oor_m_q  <= oor_f_q;
    prod_q   <= ProdW'(off_q) * ProdW'(dt_q);
    span_m_q <= span_q;
    t0_m_q   <= t0_f_q;
  end

  // interpolation divider, quotient below 16
  logic            iv_q  [DtW];
  logic            io_q  [DtW];
  logic [DtW-1:0]  iq_q  [DtW];
  logic [ResW-1:0] ir_q  [DtW];
  logic [ResW-1:0] id_q  [DtW];
  logic [DegW-1:0] it_q  [DtW];

  for (genvar k = 0; k < DtW; k++) begin : g_div2
    logic            v_in;
    logic            o_in;
    logic [DtW-1:0]  q_in;
    logic [ResW-1:0] r_in;
    logic [ResW-1:0] d_in;
    logic [DegW-1:0] t_in;
    logic [ResW:0]   trial;
    logic            ge;
    if (k == 0) begin : g_first
      assign v_in = vm_q;
      assign o_in = oor_m_q;
      assign q_in = prod_q[DtW-1:0];
      assign r_in = prod_q[ProdW-1:DtW];
      assign d_in = span_m_q;
      assign t_in = t0_m_q;
    end else begin : g_next
      assign v_in = iv_q[k-1];
      assign o_in = io_q[k-1];
      assign q_in = iq_q[k-1];
      assign r_in = ir_q[k-1];
      assign d_in = id_q[k-1];
      assign t_in = it_q[k-1];
    end
    assign trial = {r_in, q_in[DtW-1]};
    assign ge    = trial >= {1'b0, d_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) iv_q[k] <= 1'b0;
      else         iv_q[k] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      io_q[k] <= o_in;
      iq_q[k] <= {q_in[DtW-2:0], ge};
      ir_q[k] <= ge ? ResW'(trial - {1'b0, d_in}) : trial[ResW-1:0];
      id_q[k] <= d_in;
      it_q[k] <= t_in;
    end
  end

  // output register
  logic            valid_q;
  logic [DegW-1:0] temp_q;
  logic            oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= iv_q[DtW-1];
  end
  always_ff @(posedge clk_i) begin
    oor_q  <= io_q[DtW-1];
    temp_q <= io_q[DtW-1] ? DegW'(OorTemp)
                          : DegW'(it_q[DtW-1] + DegW'(iq_q[DtW-1]));
  end

  assign valid_o         = valid_q;
  assign temperature_c_o = temp_q;
  assign out_of_range_o  = oor_q;

  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##Lat valid_o) else $error("accepted word lost");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> ##Lat !valid_o) else $error("spurious result strobe");

  a_oor_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_of_range_o) |-> (temperature_c_o == DegW'(OorTemp)))
    else $error("out of range word without default temperature");

endmodule

[tb/ntc_adc_to_temperature_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NTC ADC to temperature core testbench
// Drives converter words through the command handshake, predicts each
// temperature with an independent piecewise-linear lookup and checks every
// result strobe in order against the queue of predicted temperatures.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature_core_tb;
  import ntc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 60;

  typedef struct packed {
    deg_t deg;
    logic oor;
  } temp_word_t;

  class temp_scoreboard;
    temp_word_t pending_temps[$];
    int unsigned errors;

    function temp_word_t lookup_temp(logic [AdcBitsDef-1:0] adc);
      longint mv;
      longint res;
      longint t;
      temp_word_t w;
      mv = (longint'(adc) * VrefMv) >> AdcBitsDef;
      res = (longint'(PullupOhms) * mv) / (longint'(VrefMv) - mv);
      w.deg = deg_t'(OorTemp);
      w.oor = 1'b1;
      for (int i = 0; i + 1 < TableEntries; i++) begin
        if (longint'(CurveOhms[i]) > res && longint'(CurveOhms[i+1]) <= res) begin
          t = longint'(CurveDeg[i]) + ((longint'(CurveDeg[i+1]) - longint'(CurveDeg[i]))
              * (res - longint'(CurveOhms[i])))
              / (longint'(CurveOhms[i+1]) - longint'(CurveOhms[i]));
          w.deg = deg_t'(t);
          w.oor = 1'b0;
          break;
        end
      end
      return w;
    endfunction

    function void note_sample(logic [AdcBitsDef-1:0] adc);
      pending_temps.push_back(lookup_temp(adc));
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_temp(deg_t deg, logic oor);
      temp_word_t w;
      if (pending_temps.size() == 0) begin
        report_mismatch($sformatf("unexpected word deg=%0d oor=%0b", deg, oor));
      end else begin
        w = pending_temps.pop_front();
        if (deg !== w.deg)
          report_mismatch($sformatf("temperature %0d, want %0d", deg, w.deg));
        if (oor !== w.oor)
          report_mismatch($sformatf("out_of_range %0b, want %0b", oor, w.oor));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [AdcBitsDef-1:0] adc_sample_i = '0;
  logic valid_o;
  logic [DegW-1:0] temperature_c_o;
  logic out_of_range_o;

  temp_scoreboard sb;
  int unsigned idle_cycles;
  bit calm;

  always #2 clk_i = ~clk_i;

  ntc_adc_to_temperature_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .adc_sample_i(adc_sample_i), .valid_o(valid_o),
    .temperature_c_o(temperature_c_o), .out_of_range_o(out_of_range_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check_temp(temperature_c_o, out_of_range_o);
      if ((start && !busy) || valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task send_sample(logic [AdcBitsDef-1:0] adc);
    while (!calm && $urandom_range(99) < 8) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    adc_sample_i <= adc;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_sample(adc);
  endtask

  task wait_drained();
    start <= 1'b0;
    while (sb.pending_temps.size() != 0) @(posedge clk_i);
  endtask

  // adc words weighted toward both ends of the adc range
  function logic [AdcBitsDef-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return AdcBitsDef'($urandom_range(20, 1010));
    if (r < 70) return AdcBitsDef'($urandom_range(0, 25));
    if (r < 80) return AdcBitsDef'($urandom_range(1000, 1023));
    return AdcBitsDef'($urandom);
  endfunction

  initial begin
    sb = new();
    idle_cycles = 0;
    calm = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (CurveOhms[i]) begin
      // word whose resistance lands near each table point
      send_sample(AdcBitsDef'((longint'(CurveOhms[i]) * 1024) / (CurveOhms[i] + PullupOhms)));
    end
    send_sample('0);
    send_sample(10'h3ff);
    send_sample(10'd1);
    send_sample(10'h2aa);
    send_sample(10'h155);
    send_sample(10'd640);
    send_sample(10'd1000);
    wait_drained();
    for (int n = 0; n < 400; n++) begin
      calm = (n >= 150 && n < 250);
      send_sample(pick_sample());
      if (n == 300) wait_drained();
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_temps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/ntc_pkg.sv
rtl/ntc_adc_to_temperature_core.sv
tb/ntc_adc_to_temperature_core_tb.sv
